[hw/rtl/lwe_pkg.sv]
package lwe_pkg;

	// Width of the register index on the configuration channel.
	localparam int unsigned CFG_IDX_W = 3;

	localparam int unsigned TIME_WIDTH_DEF = 32;

	// Operation codes carried in the op field of a request beat.
	localparam logic [1:0] OP_CHECK = 2'd0;
	localparam logic [1:0] OP_KICK  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STALL_TMO    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FAIL     = 3'd4;

	// Register values after reset.
	localparam logic        ENABLE_RST       = 1'b1;
	localparam logic [31:0] CHECK_PERIOD_RST = 32'd100;
	localparam logic [31:0] STALL_TMO_RST    = 32'd1000;
	localparam logic [31:0] COOLDOWN_RST     = 32'd5000;
	localparam logic [7:0]  MAX_FAIL_RST     = 8'd3;

	localparam logic [7:0]  TALLY_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now_ms;
	} lwe_req_t;

	typedef struct packed {
		logic       alive;
		logic       stalled;
		logic       escalated;
		logic [7:0] failure_count;
		logic       reboot_request;
	} lwe_rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          data;
	} lwe_cfg_t;

endpackage

[hw/rtl/lwe_stream_if.sv]
interface lwe_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/liveness_watchdog_escalator_unit.sv]
// Channel  Modport  Payload     Beat
// req      sink     lwe_req_t   one operation (check, kick, clear) with its timestamp
// rsp      source   lwe_rsp_t   one status beat for every request beat
// cfg      sink     lwe_cfg_t   one register write; always ready
//
// A request beat is registered at the input, evaluated against the watchdog state while it
// sits in the input stage and written to the response register together with the state update.
// Throughput is one beat per cycle while the response register is not stalled.
// A stalled response register holds the input stage, and req.ready then follows rsp.ready.
// arst_n returns the registers to their defaults and the watchdog state to idle.
module liveness_watchdog_escalator_unit #(
	parameter int unsigned TIME_WIDTH = lwe_pkg::TIME_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lwe_stream_if.sink   req,
	lwe_stream_if.source rsp,
	lwe_stream_if.sink   cfg
);
	import lwe_pkg::*;

	// Compare width covers both the time difference and the 32-bit registers.
	localparam int unsigned CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	// Configuration registers.
	logic        enable_q;
	logic [31:0] check_period_q;
	logic [31:0] stall_tmo_q;
	logic [31:0] cooldown_q;
	logic [7:0]  max_fail_q;

	// Watchdog state.
	logic                  was_kicked_q;
	logic [TIME_WIDTH-1:0] last_kick_q;
	logic [TIME_WIDTH-1:0] last_check_q;
	logic [TIME_WIDTH-1:0] last_recovery_q;
	logic [7:0]            tally_q;
	logic                  alive_q;
	logic                  stall_q;

	// Input stage and response register.
	logic     req_valid_s1;
	lwe_req_t req_s1;
	logic     rsp_valid_q;
	lwe_rsp_t rsp_q;

	logic s1_adv;

	// Next-state and result logic.
	logic [CW-1:0]         now_ext;
	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] age_check;
	logic [TIME_WIDTH-1:0] age_kick;
	logic [TIME_WIDTH-1:0] age_recovery;
	logic                  check_due;
	logic                  kick_old;
	logic                  cooldown_over;
	logic [7:0]            tally_inc;

	logic                  was_kicked_d;
	logic [TIME_WIDTH-1:0] last_kick_d;
	logic [TIME_WIDTH-1:0] last_check_d;
	logic [TIME_WIDTH-1:0] last_recovery_d;
	logic [7:0]            tally_d;
	logic                  alive_d;
	logic                  stall_d;
	logic                  escalated_c;
	logic                  reboot_c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= ENABLE_RST;
			check_period_q <= CHECK_PERIOD_RST;
			stall_tmo_q    <= STALL_TMO_RST;
			cooldown_q     <= COOLDOWN_RST;
			max_fail_q     <= MAX_FAIL_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_ENABLE:       enable_q       <= cfg.data.data[0];
				REG_CHECK_PERIOD: check_period_q <= cfg.data.data;
				REG_STALL_TMO:    stall_tmo_q    <= cfg.data.data;
				REG_COOLDOWN:     cooldown_q     <= cfg.data.data;
				REG_MAX_FAIL:     max_fail_q     <= cfg.data.data[7:0];
				default: ;
			endcase
		end
	end

	assign s1_adv    = req_valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !req_valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			req_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	// Timestamps are truncated or zero-extended to TIME_WIDTH bits; all ages wrap at that width.
	assign now_ext      = CW'(req_s1.now_ms);
	assign now_t        = now_ext[TIME_WIDTH-1:0];
	assign age_check    = now_t - last_check_q;
	assign age_kick     = now_t - last_kick_q;
	assign age_recovery = now_t - last_recovery_q;

	assign check_due     = CW'(age_check) >= CW'(check_period_q);
	assign kick_old      = CW'(age_kick) > CW'(stall_tmo_q);
	assign cooldown_over = CW'(age_recovery) > CW'(cooldown_q);
	assign tally_inc     = (tally_q == TALLY_MAX) ? tally_q : tally_q + 8'd1;

	always_comb begin
		was_kicked_d    = was_kicked_q;
		last_kick_d     = last_kick_q;
		last_check_d    = last_check_q;
		last_recovery_d = last_recovery_q;
		tally_d         = tally_q;
		alive_d         = alive_q;
		stall_d         = stall_q;
		escalated_c     = 1'b0;
		reboot_c        = 1'b0;
		case (req_s1.op)
			OP_CLEAR: begin
				was_kicked_d    = 1'b0;
				last_kick_d     = '0;
				last_check_d    = '0;
				last_recovery_d = '0;
				tally_d         = '0;
				alive_d         = 1'b1;
				stall_d         = 1'b0;
			end
			OP_KICK: begin
				if (enable_q) begin
					was_kicked_d = 1'b1;
					last_kick_d  = now_t;
					alive_d      = 1'b1;
					stall_d      = 1'b0;
					tally_d      = '0;
				end
			end
			OP_CHECK: begin
				if (enable_q && check_due) begin
					last_check_d = now_t;
					if (was_kicked_q) begin
						if (kick_old) begin
							alive_d = 1'b0;
							stall_d = 1'b1;
							if (cooldown_over) begin
								escalated_c     = 1'b1;
								last_recovery_d = now_t;
								tally_d         = tally_inc;
								reboot_c        = tally_inc >= max_fail_q;
							end
						end else begin
							stall_d = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_kicked_q    <= 1'b0;
			last_kick_q     <= '0;
			last_check_q    <= '0;
			last_recovery_q <= '0;
			tally_q         <= '0;
			alive_q         <= 1'b1;
			stall_q         <= 1'b0;
		end else if (s1_adv) begin
			// A reboot reports the escalated state and then drops back to idle.
			if (reboot_c) begin
				was_kicked_q    <= 1'b0;
				last_kick_q     <= '0;
				last_check_q    <= '0;
				last_recovery_q <= '0;
				tally_q         <= '0;
				alive_q         <= 1'b1;
				stall_q         <= 1'b0;
			end else begin
				was_kicked_q    <= was_kicked_d;
				last_kick_q     <= last_kick_d;
				last_check_q    <= last_check_d;
				last_recovery_q <= last_recovery_d;
				tally_q         <= tally_d;
				alive_q         <= alive_d;
				stall_q         <= stall_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.alive          <= alive_d;
			rsp_q.stalled        <= stall_d;
			rsp_q.escalated      <= escalated_c;
			rsp_q.failure_count  <= tally_d;
			rsp_q.reboot_request <= reboot_c;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	a_alive_excl_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(alive_q && stall_q))
		else $error("alive and stalled set together");

	a_reboot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && reboot_c |=> !was_kicked_q && tally_q == 8'd0 && alive_q)
		else $error("state not cleared after reboot");

	a_reboot_escalated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.reboot_request |-> rsp_q.escalated && rsp_q.stalled
			&& !rsp_q.alive)
		else $error("reboot without escalation");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 && !s1_adv |=> req_valid_s1 && $stable(req_s1))
		else $error("input stage lost a beat under stall");

	a_rsp_one_per_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !s1_adv)
		else $error("response register overwritten");

endmodule

[dv/lwe_status_checker.sv]
`timescale 1ns / 1ps

module lwe_status_checker
	import lwe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  lwe_req_t    req_data,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  lwe_rsp_t    rsp_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  lwe_cfg_t    cfg_data,
	output int unsigned fail_count,
	output int unsigned open_results
);

	localparam int unsigned PRINT_LIMIT = 40;

	// Register copies
	logic        enable_r;
	logic [31:0] period_r;
	logic [31:0] timeout_r;
	logic [31:0] cooldown_r;
	logic [7:0]  max_fail_r;

	// Watchdog state
	logic        kicked;
	logic [31:0] kick_at;
	logic [31:0] check_at;
	logic [31:0] recovery_at;
	logic [7:0]  tally;
	logic        alive_st;
	logic        stall_st;

	lwe_rsp_t    status_fifo[$];
	int unsigned mismatches = 0;
	int unsigned pending = 0;

	assign fail_count   = mismatches;
	assign open_results = pending;

	function automatic void clear_watchdog();
		kicked      = 1'b0;
		kick_at     = '0;
		check_at    = '0;
		recovery_at = '0;
		tally       = '0;
		alive_st    = 1'b1;
		stall_st    = 1'b0;
	endfunction

	// Applies one request beat to the watchdog state and returns the status it reports.
	function automatic lwe_rsp_t step_watchdog(input lwe_req_t beat);
		lwe_rsp_t    st;
		logic        escalate;
		logic        reboot;
		logic [31:0] since_check;
		logic [31:0] kick_age;
		logic [31:0] since_recovery;
		escalate       = 1'b0;
		reboot         = 1'b0;
		since_check    = beat.now_ms - check_at;
		kick_age       = beat.now_ms - kick_at;
		since_recovery = beat.now_ms - recovery_at;
		case (beat.op)
			OP_CLEAR: begin
				clear_watchdog();
			end
			OP_KICK: begin
				if (enable_r) begin
					kicked   = 1'b1;
					kick_at  = beat.now_ms;
					alive_st = 1'b1;
					stall_st = 1'b0;
					tally    = '0;
				end
			end
			OP_CHECK: begin
				if (enable_r && since_check >= period_r) begin
					check_at = beat.now_ms;
					if (kicked) begin
						if (kick_age > timeout_r) begin
							alive_st = 1'b0;
							stall_st = 1'b1;
							if (since_recovery > cooldown_r) begin
								escalate    = 1'b1;
								recovery_at = beat.now_ms;
								if (tally != TALLY_MAX)
									tally = tally + 8'd1;
								if (tally >= max_fail_r)
									reboot = 1'b1;
							end
						end else begin
							stall_st = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase
		st.alive          = alive_st;
		st.stalled        = stall_st;
		st.escalated      = escalate;
		st.failure_count  = tally;
		st.reboot_request = reboot;
		// The reboot beat still shows the state that caused it; the state resets afterwards.
		if (reboot)
			clear_watchdog();
		return st;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t ns: status mismatch on %s: got %0h, expected %0h",
				$time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lwe_rsp_t got;
		lwe_rsp_t want;
		if (!arst_n) begin
			enable_r   = ENABLE_RST;
			period_r   = CHECK_PERIOD_RST;
			timeout_r  = STALL_TMO_RST;
			cooldown_r = COOLDOWN_RST;
			max_fail_r = MAX_FAIL_RST;
			clear_watchdog();
			status_fifo.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_ENABLE:       enable_r   = cfg_data.data[0];
					REG_CHECK_PERIOD: period_r   = cfg_data.data;
					REG_STALL_TMO:    timeout_r  = cfg_data.data;
					REG_COOLDOWN:     cooldown_r = cfg_data.data;
					REG_MAX_FAIL:     max_fail_r = cfg_data.data[7:0];
					default: begin
					end
				endcase
			end
			if (req_valid && req_ready)
				status_fifo.push_back(step_watchdog(req_data));
			if (rsp_valid && rsp_ready) begin
				if (status_fifo.size() == 0) begin
					report_mismatch("unexpected status beat", 32'(rsp_data), '0);
				end else begin
					want = status_fifo.pop_front();
					got  = rsp_data;
					if (got.alive !== want.alive)
						report_mismatch("alive", 32'(got.alive), 32'(want.alive));
					if (got.stalled !== want.stalled)
						report_mismatch("stalled", 32'(got.stalled), 32'(want.stalled));
					if (got.escalated !== want.escalated)
						report_mismatch("escalated", 32'(got.escalated),
							32'(want.escalated));
					if (got.failure_count !== want.failure_count)
						report_mismatch("failure_count", 32'(got.failure_count),
							32'(want.failure_count));
					if (got.reboot_request !== want.reboot_request)
						report_mismatch("reboot_request", 32'(got.reboot_request),
							32'(want.reboot_request));
				end
			end
			pending <= status_fifo.size();
		end
	end

endmodule

[dv/liveness_watchdog_escalator_unit_test.sv]
`timescale 1ns / 1ps

module liveness_watchdog_escalator_unit_test;
	import lwe_pkg::*;

	// The op code and a register index that the block has no use for.
	localparam logic [1:0]           OP_NONE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam int unsigned RSP_HOLD_CYCLES = 64;
	localparam int unsigned SETTLE_CYCLES   = 4;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        hold_req  = 1'b0;
	logic        hold_seen = 1'b0;
	logic        tx_quiet  = 1'b0;
	logic        rx_quiet  = 1'b0;
	logic [31:0] stamp;
	int unsigned fail_count;
	int unsigned open_results;

	lwe_stream_if #(.payload_t(lwe_req_t)) req_if ();
	lwe_stream_if #(.payload_t(lwe_rsp_t)) rsp_if ();
	lwe_stream_if #(.payload_t(lwe_cfg_t)) cfg_if ();

	liveness_watchdog_escalator_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	lwe_status_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_if.valid),
		.req_ready    (req_if.ready),
		.req_data     (req_if.data),
		.rsp_valid    (rsp_if.valid),
		.rsp_ready    (rsp_if.ready),
		.rsp_data     (rsp_if.data),
		.cfg_valid    (cfg_if.valid),
		.cfg_ready    (cfg_if.ready),
		.cfg_data     (cfg_if.data),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Status receiver. A hold is pending while hold_req and hold_seen differ.
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				rsp_if.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
				hold_seen    <= hold_req;
				rsp_if.ready <= 1'b1;
			end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				repeat ($urandom_range(0, 10)) @(posedge clk);
			end
		end
	end

	// Returns at the edge where the beat is taken; valid stays high for a following beat.
	task automatic send_op(input logic [1:0] op, input logic [31:0] ts);
		req_if.valid <= 1'b1;
		req_if.data  <= '{op: op, now_ms: ts};
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic pause();
		if (!tx_quiet && $urandom_range(0, 99) < 20) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= '{index: idx, data: val};
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	// Unused data bits of the narrow registers carry random junk.
	task automatic set_regs(input logic en, input logic [31:0] period, input logic [31:0] tmo,
			input logic [31:0] cooldown, input logic [7:0] maxf);
		logic [31:0] junk;
		junk    = $urandom();
		junk[0] = en;
		cfg_beat(REG_ENABLE, junk);
		cfg_beat(REG_CHECK_PERIOD, period);
		cfg_beat(REG_STALL_TMO, tmo);
		cfg_beat(REG_COOLDOWN, cooldown);
		junk      = $urandom();
		junk[7:0] = maxf;
		cfg_beat(REG_MAX_FAIL, junk);
		cfg_beat(REG_SPARE, $urandom());
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Time moves forward by a random step per beat; noise is clears, unused ops and jumps.
	task automatic run_phase(input int unsigned count, input int unsigned step_lo,
			input int unsigned step_hi, input int unsigned kick_pct,
			input int unsigned noise_pct);
		int unsigned pick;
		logic [1:0]  op;
		for (int unsigned i = 0; i < count; i++) begin
			pick  = $urandom_range(0, 99);
			stamp = stamp + $urandom_range(step_lo, step_hi);
			if (pick < noise_pct) begin
				case ($urandom_range(0, 2))
					0: op = OP_CLEAR;
					1: op = OP_NONE;
					default: begin
						op    = OP_CHECK;
						stamp = $urandom();
					end
				endcase
			end else if (pick < noise_pct + kick_pct) begin
				op = OP_KICK;
			end else begin
				op = OP_CHECK;
			end
			send_op(op, stamp);
			pause();
		end
	endtask

	initial begin
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults after reset: escalation every cooldown, reboot on the third.
		send_op(OP_CHECK, 32'd0);
		send_op(OP_NONE, 32'd50);
		send_op(OP_KICK, 32'd200);
		send_op(OP_CHECK, 32'd300);
		send_op(OP_CHECK, 32'd1300);
		send_op(OP_CHECK, 32'd5500);
		send_op(OP_CHECK, 32'd5550);
		send_op(OP_CHECK, 32'd10600);
		send_op(OP_CHECK, 32'd15700);
		send_op(OP_CHECK, 32'd15800);
		send_op(OP_KICK, 32'hFFFF_FF00);
		send_op(OP_CHECK, 32'h0000_0400);
		send_op(OP_KICK, 32'h0000_0500);
		send_op(OP_CLEAR, 32'hA5A5_5A5A);
		send_op(OP_KICK, 32'hFFFF_FFFF);
		send_op(OP_CHECK, 32'hFFFF_FFFF);
		send_op(OP_NONE, 32'hFFFF_FFFF);
		drain();

		// Disabled: kicks and checks do nothing, a clear still acts.
		set_regs(1'b0, CHECK_PERIOD_RST, STALL_TMO_RST, COOLDOWN_RST, MAX_FAIL_RST);
		send_op(OP_KICK, 32'd7000);
		send_op(OP_CHECK, 32'd9000);
		send_op(OP_CLEAR, 32'd9100);
		send_op(OP_CHECK, 32'd9200);
		drain();

		// Longest period and a zero maximum: the one check that passes reboots.
		set_regs(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd0);
		send_op(OP_KICK, 32'd5);
		send_op(OP_CHECK, 32'hFFFF_FFFF);
		send_op(OP_CHECK, 32'h8000_0000);
		drain();

		set_regs(1'b1, CHECK_PERIOD_RST, STALL_TMO_RST, COOLDOWN_RST, MAX_FAIL_RST);
		stamp = $urandom();
		run_phase(120, 0, 600, 5, 4);
		// The receiver holds off for a long stretch while beats keep coming.
		hold_req <= ~hold_req;
		tx_quiet <= 1'b1;
		run_phase(40, 0, 600, 5, 4);
		tx_quiet <= 1'b0;
		run_phase(130, 0, 600, 5, 4);
		drain();

		// Each check escalates until the reboot, so the tally climbs all the way to 255.
		set_regs(1'b1, 32'd0, 32'd0, 32'd0, 8'd255);
		send_op(OP_KICK, stamp);
		run_phase(300, 1, 3, 0, 0);
		drain();

		set_regs(1'b0, $urandom_range(0, 100), $urandom_range(0, 1000),
			$urandom_range(0, 3000), 8'($urandom_range(1, 4)));
		run_phase(80, 0, 500, 20, 10);
		drain();

		repeat (4) begin
			set_regs(1'b1, $urandom_range(0, 60), $urandom_range(0, 400),
				$urandom_range(0, 800), 8'($urandom_range(1, 5)));
			stamp = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			run_phase(110, 0, 150, 6, 4);
			drain();
		end

		set_regs(1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
		run_phase(60, 0, 32'hFFFF, 10, 10);
		drain();

		set_regs(1'b1, 32'd20, 32'd300, 32'd600, 8'd2);
		tx_quiet <= 1'b1;
		rx_quiet <= 1'b1;
		run_phase(150, 0, 120, 6, 4);
		drain();

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/lwe_pkg.sv
hw/rtl/lwe_stream_if.sv
hw/rtl/liveness_watchdog_escalator_unit.sv
dv/lwe_status_checker.sv
dv/liveness_watchdog_escalator_unit_test.sv
